FILE: hw/rtl/rde_pkg.sv
// Shared types, constants and calendar tables for the RFC 822 date converter.
package rde_pkg;

   localparam int YEAR_W  = 14;
   localparam int ABBR_W  = 24;
   localparam int FIELD_W = 7;
   localparam int MONTH_W = 4;
   localparam int CENT_W  = 8;
   localparam int DOY_W   = 9;
   localparam int MLEN_W  = 5;
   localparam int DAYS_W  = 24;
   localparam int SECS_W  = 41;
   localparam int EPOCH_W = 38;
   localparam int STAT_W  = 3;
   localparam int NUM_MONTHS = 12;

   // floor(x / 25) for x below 4096 as (x * RECIP_25) >> RECIP_SHIFT.
   localparam int RECIP_W     = 12;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_25 = 12'd2622;
   localparam int QUOT_W = 2 * RECIP_W;

   localparam int EPOCH_SHIFT   = 719468;
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAYS_PER_YEAR = 365;
   localparam int YEARS_PER_CENT = 100;

   localparam logic [FIELD_W-1:0] MAX_HOUR   = 7'd23;
   localparam logic [FIELD_W-1:0] MAX_MINUTE = 7'd59;
   localparam logic [FIELD_W-1:0] MAX_SECOND = 7'd60;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [ABBR_W-1:0] MONTH_CODES [NUM_MONTHS] = '{
      24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
      24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
   };

   localparam logic [MLEN_W-1:0] MONTH_LEN [NUM_MONTHS] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Day offset of each month's first day in a year that starts in March.
   localparam logic [DOY_W-1:0] MONTH_DOY [NUM_MONTHS] = '{
      9'd306, 9'd337, 9'd0, 9'd31, 9'd61, 9'd92,
      9'd122, 9'd153, 9'd184, 9'd214, 9'd245, 9'd275
   };

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 3'd0,
      ST_MONTH = 3'd1,
      ST_DAY   = 3'd2,
      ST_TIME  = 3'd3,
      ST_ZONE  = 3'd4,
      ST_EARLY = 3'd5
   } status_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [YEAR_W-1:0]  yadj;
      logic               yneg;
      logic [CENT_W-1:0]  c_year;
      logic [CENT_W-1:0]  c_yadj;
      logic [MONTH_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic               zone_ok;
   } decode_type;

   typedef struct packed {
      logic signed [DAYS_W-1:0] days;
      status_type         status;
      logic               yneg;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } days_type;

   typedef struct packed {
      logic [SECS_W-1:0] secs;
      status_type        status;
      logic              yneg;
   } secs_type;

   function automatic logic [MONTH_W-1:0] month_decode(input logic [ABBR_W-1:0] abbr);
      logic [MONTH_W-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_MONTHS; i++) begin
         if (abbr == MONTH_CODES[i]) begin
            m = MONTH_W'(i + 1);
         end
      end
      return m;
   endfunction

   function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                       input logic leap);
      logic [MONTH_W-1:0] idx;
      logic [MLEN_W-1:0]  len;
      idx = month - MONTH_W'(1);
      len = '0;
      if (month == MONTH_FEB && leap) begin
         len = 5'd29;
      end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
         len = MONTH_LEN[idx];
      end
      return len;
   endfunction

   function automatic logic [DOY_W-1:0] month_doy(input logic [MONTH_W-1:0] month);
      logic [MONTH_W-1:0] idx;
      logic [DOY_W-1:0]   doy;
      idx = month - MONTH_W'(1);
      doy = '0;
      if (month >= MONTH_JAN && month <= MONTH_DEC) begin
         doy = MONTH_DOY[idx];
      end
      return doy;
   endfunction

endpackage

FILE: hw/rtl/rde_if.sv
// Request and response channel interfaces of the date converter.
interface rde_req_if;
   logic                          valid;
   logic                          ready;
   logic [rde_pkg::YEAR_W-1:0]    year;
   logic [rde_pkg::ABBR_W-1:0]    month_abbr;
   logic [rde_pkg::FIELD_W-1:0]   day;
   logic [rde_pkg::FIELD_W-1:0]   hour;
   logic [rde_pkg::FIELD_W-1:0]   minute;
   logic [rde_pkg::FIELD_W-1:0]   second;
   logic                          zone_is_utc;

   modport source (output valid, year, month_abbr, day, hour, minute, second, zone_is_utc,
                   input ready);
   modport sink (input valid, year, month_abbr, day, hour, minute, second, zone_is_utc,
                 output ready);
endinterface

interface rde_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rde_pkg::EPOCH_W-1:0]   epoch_seconds;
   logic [rde_pkg::STAT_W-1:0]    status;

   modport source (output valid, epoch_seconds, status, input ready);
   modport sink (input valid, epoch_seconds, status, output ready);
endinterface

FILE: hw/rtl/rfc822_date_to_epoch.sv
// A transaction accepted on req_ch passes each register stage in turn; bubbles close up.
// Throughput: one transaction per cycle while rsp_ch is ready, through four register
// stages (decode, day count, seconds multiply, output), each with its own valid bit.
// Stalls on rsp_ch back up stage by stage; req_ch.ready drops only when all are full.
// Reset (synchronous, active high) clears the valid bits only; no clearing pass.
module rfc822_date_to_epoch (
   input  logic       clock,
   input  logic       reset,
   rde_req_if.sink    req_ch,
   rde_rsp_if.source  rsp_ch
);
   import rde_pkg::*;

   logic               a_valid;
   logic               a_ready;
   decode_type         a_data;
   logic               b_valid;
   logic               b_ready;
   days_type           b_data;
   logic               c_valid;
   logic               c_ready;
   secs_type           c_data;

   logic               d_vld_ff;
   status_type         d_status_ff;
   status_type         d_status_in;
   logic [EPOCH_W-1:0] d_epoch_ff;
   logic [EPOCH_W-1:0] d_epoch_in;

   rde_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .year        (req_ch.year),
      .month_abbr  (req_ch.month_abbr),
      .day         (req_ch.day),
      .hour        (req_ch.hour),
      .minute      (req_ch.minute),
      .second      (req_ch.second),
      .zone_is_utc (req_ch.zone_is_utc),
      .out_valid   (a_valid),
      .out_data    (a_data),
      .out_ready   (a_ready)
   );

   rde_days u_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .in_ready  (a_ready),
      .in_data   (a_data),
      .out_valid (b_valid),
      .out_data  (b_data),
      .out_ready (b_ready)
   );

   rde_secs u_secs (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_data   (b_data),
      .out_valid (c_valid),
      .out_data  (c_data),
      .out_ready (c_ready)
   );

   always_comb begin
      // A date before the epoch, including a year that underflows, is reported last.
      if (c_data.status == ST_OK && (c_data.yneg || c_data.secs[SECS_W-1])) begin
         d_status_in = ST_EARLY;
      end else begin
         d_status_in = c_data.status;
      end
      if (d_status_in == ST_OK) begin
         d_epoch_in = c_data.secs[EPOCH_W-1:0];
      end else begin
         d_epoch_in = '0;
      end
   end

   assign c_ready = !d_vld_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (c_ready) begin
         d_vld_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && c_valid) begin
         d_status_ff <= d_status_in;
         d_epoch_ff  <= d_epoch_in;
      end
   end

   assign rsp_ch.valid         = d_vld_ff;
   assign rsp_ch.status        = d_status_ff;
   assign rsp_ch.epoch_seconds = d_epoch_ff;

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && d_status_ff != ST_OK) |-> (d_epoch_ff == '0))
      else $error("failed transaction carries nonzero seconds");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (a_valid && b_valid && c_valid && d_vld_ff && !rsp_ch.ready))
      else $error("request stalled while the pipeline has a free stage");

   a_reset_empty : assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_ch.valid)
      else $error("response valid right after reset");
endmodule

FILE: hw/rtl/rde_decode.sv
// First stage: month name decode, year adjust and century quotients.
module rde_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rde_pkg::YEAR_W-1:0]  year,
   input  logic [rde_pkg::ABBR_W-1:0]  month_abbr,
   input  logic [rde_pkg::FIELD_W-1:0] day,
   input  logic [rde_pkg::FIELD_W-1:0] hour,
   input  logic [rde_pkg::FIELD_W-1:0] minute,
   input  logic [rde_pkg::FIELD_W-1:0] second,
   input  logic                        zone_is_utc,
   output logic                        out_valid,
   output rde_pkg::decode_type         out_data,
   input  logic                        out_ready
);
   import rde_pkg::*;

   logic               vld_ff;
   decode_type         data_ff;
   decode_type         data_in;
   logic [MONTH_W-1:0] month;
   logic               jan_feb;
   logic [QUOT_W-1:0]  prod_year;
   logic [QUOT_W-1:0]  prod_yadj;

   assign month   = month_decode(month_abbr);
   assign jan_feb = (month == MONTH_JAN) || (month == MONTH_FEB);

   always_comb begin
      data_in.year    = year;
      // January and February count as the end of the previous year.
      data_in.yadj    = year - YEAR_W'(jan_feb);
      data_in.yneg    = jan_feb && (year == '0);
      data_in.month   = month;
      data_in.day     = day;
      data_in.hour    = hour;
      data_in.minute  = minute;
      data_in.second  = second;
      data_in.zone_ok = zone_is_utc;
      prod_year = QUOT_W'(year[YEAR_W-1:2]) * QUOT_W'(RECIP_25);
      prod_yadj = QUOT_W'(data_in.yadj[YEAR_W-1:2]) * QUOT_W'(RECIP_25);
      data_in.c_year = prod_year[RECIP_SHIFT +: CENT_W];
      data_in.c_yadj = prod_yadj[RECIP_SHIFT +: CENT_W];
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/rde_days.sv
// Second stage: range checks and day count since the epoch.
module rde_days (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rde_pkg::decode_type in_data,
   output logic                out_valid,
   output rde_pkg::days_type   out_data,
   input  logic                out_ready
);
   import rde_pkg::*;

   logic                vld_ff;
   days_type            data_ff;
   days_type            data_in;
   logic [YEAR_W:0]     cent_x100;
   logic                div4;
   logic                div100;
   logic                leap;
   logic [MLEN_W-1:0]   mlen;
   logic                time_ok;
   logic [DAYS_W-1:0]   pos_sum;
   logic [DAYS_W-1:0]   neg_sum;

   always_comb begin
      cent_x100 = (YEAR_W + 1)'(in_data.c_year) * (YEAR_W + 1)'(YEARS_PER_CENT);
      div4      = (in_data.year[1:0] == 2'b00);
      div100    = (cent_x100 == {1'b0, in_data.year});
      // A century year is a leap year only when the century count divides by four.
      leap      = div4 && (!div100 || (in_data.c_year[1:0] == 2'b00));
      mlen      = month_length(in_data.month, leap);
      time_ok   = (in_data.hour <= MAX_HOUR) && (in_data.minute <= MAX_MINUTE)
                  && (in_data.second <= MAX_SECOND);

      pos_sum = DAYS_W'(in_data.yadj) * DAYS_W'(DAYS_PER_YEAR)
              + DAYS_W'(in_data.yadj[YEAR_W-1:2])
              + DAYS_W'(in_data.c_yadj[CENT_W-1:2])
              + DAYS_W'(month_doy(in_data.month))
              + DAYS_W'(in_data.day);
      neg_sum = DAYS_W'(in_data.c_yadj) + DAYS_W'(EPOCH_SHIFT + 1);

      data_in.days   = $signed(pos_sum - neg_sum);
      data_in.yneg   = in_data.yneg;
      data_in.hour   = in_data.hour;
      data_in.minute = in_data.minute;
      data_in.second = in_data.second;

      if (in_data.month == '0) begin
         data_in.status = ST_MONTH;
      end else if (in_data.day == '0 || MLEN_W'(in_data.day) > mlen
                   || in_data.day[FIELD_W-1:MLEN_W] != '0) begin
         data_in.status = ST_DAY;
      end else if (!time_ok) begin
         data_in.status = ST_TIME;
      end else if (!in_data.zone_ok) begin
         data_in.status = ST_ZONE;
      end else begin
         data_in.status = ST_OK;
      end
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/rde_secs.sv
// Third stage: day count and time of day to signed seconds.
module rde_secs (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rde_pkg::days_type in_data,
   output logic              out_valid,
   output rde_pkg::secs_type out_data,
   input  logic              out_ready
);
   import rde_pkg::*;

   logic              vld_ff;
   secs_type          data_ff;
   secs_type          data_in;
   logic [SECS_W-1:0] day_secs;
   logic [SECS_W-1:0] tod_secs;

   always_comb begin
      // Two's complement product; the sign survives in the top bit.
      day_secs = SECS_W'(in_data.days) * SECS_W'(SECS_PER_DAY);
      tod_secs = SECS_W'(in_data.hour) * SECS_W'(SECS_PER_HOUR)
               + SECS_W'(in_data.minute) * SECS_W'(SECS_PER_MIN)
               + SECS_W'(in_data.second);
      data_in.secs   = day_secs + tod_secs;
      data_in.status = in_data.status;
      data_in.yneg   = in_data.yneg;
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;
endmodule

FILE: tb/sv/rfc822_date_to_epoch_tb.sv
// Self-checking testbench for rfc822_date_to_epoch: directed and random dates scored live.
`timescale 1ns / 100ps

module rfc822_date_to_epoch_tb;
   import rde_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_DATES = 1400;
   localparam int PRINT_CAP    = 50;

   localparam logic [ABBR_W-1:0] MONTH_NAMES [12] = '{
      "Jan", "Feb", "Mar", "Apr", "May", "Jun",
      "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
   };
   localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [ABBR_W-1:0]  abbr;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
      logic               utc;
   } date_type;

   typedef struct {
      date_type           src;
      logic [EPOCH_W-1:0] epoch;
      status_type         status;
   } stamp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   send_steady = 1'b0;
   bit   take_steady = 1'b0;
   int   quiet_cycles = 0;

   rde_req_if req_ch ();
   rde_rsp_if rsp_ch ();

   rfc822_date_to_epoch dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Gregorian month length; year 0 counts as a leap year.
   function automatic int month_span(input int year, input int month);
      int len;
      len = MONTH_DAYS[month - 1];
      if (month == 2 && ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0)) begin
         len = 29;
      end
      return len;
   endfunction

   class epoch_scoreboard;
      stamp_type   stamps_due[$];
      int unsigned errors = 0;

      function int month_number(input logic [ABBR_W-1:0] abbr);
         for (int i = 0; i < 12; i++) begin
            if (abbr == MONTH_NAMES[i]) begin
               return i + 1;
            end
         end
         return 0;
      endfunction

      // Days-from-civil conversion, with the checks taken in the block's order.
      function stamp_type date_to_stamp(input date_type d);
         stamp_type s;
         int     m;
         longint y, era, yoe, doy, doe, days, secs;
         s.src    = d;
         s.epoch  = '0;
         s.status = ST_OK;
         m = month_number(d.abbr);
         if (m == 0) begin
            s.status = ST_MONTH;
         end else if (d.day == 0 || int'(d.day) > month_span(int'(d.year), m)) begin
            s.status = ST_DAY;
         end else if (d.hour > 23 || d.minute > 59 || d.second > 60) begin
            s.status = ST_TIME;
         end else if (!d.utc) begin
            s.status = ST_ZONE;
         end else begin
            y = longint'(d.year);
            if (m <= 2) begin
               y = y - 1;
            end
            era  = (y >= 0 ? y : y - 399) / 400;
            yoe  = y - era * 400;
            doy  = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + longint'(d.day) - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            secs = days * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60
                 + longint'(d.second);
            if (secs < 0) begin
               s.status = ST_EARLY;
            end else begin
               s.epoch = secs[EPOCH_W-1:0];
            end
         end
         return s;
      endfunction

      function void note_date(input date_type d);
         stamps_due.push_back(date_to_stamp(d));
      endfunction

      task flag_mismatch(input string what);
         if (errors < PRINT_CAP) begin
            $display("[%0t] MISMATCH %s", $time, what);
         end
         errors++;
      endtask

      task check_stamp(input logic [EPOCH_W-1:0] epoch, input logic [STAT_W-1:0] status);
         stamp_type want;
         if (stamps_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result epoch=%0d status=%0d", epoch, status));
            return;
         end
         want = stamps_due.pop_front();
         if (status !== want.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d for %p",
                                    status, want.status, want.src));
         end
         if (epoch !== want.epoch) begin
            flag_mismatch($sformatf("epoch %0d, expected %0d for %p",
                                    epoch, want.epoch, want.src));
         end
      endtask
   endclass

   epoch_scoreboard sb = new();

   function automatic date_type date_of(input int y, input logic [ABBR_W-1:0] a, input int d,
                                        input int h, input int mi, input int s, input bit u);
      date_type r;
      r.year   = YEAR_W'(y);
      r.abbr   = a;
      r.day    = FIELD_W'(d);
      r.hour   = FIELD_W'(h);
      r.minute = FIELD_W'(mi);
      r.second = FIELD_W'(s);
      r.utc    = u;
      return r;
   endfunction

   // Mostly zero, often short, now and then a long pause.
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Well-formed dates with random content dominate; the rest is noise or near misses.
   function automatic date_type random_date();
      date_type d;
      int    r, m, len;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         d.year   = YEAR_W'($urandom);
         d.abbr   = ABBR_W'($urandom);
         d.day    = FIELD_W'($urandom);
         d.hour   = FIELD_W'($urandom);
         d.minute = FIELD_W'($urandom);
         d.second = FIELD_W'($urandom);
         d.utc    = 1'($urandom);
         return d;
      end
      m = $urandom_range(1, 12);
      d.abbr = MONTH_NAMES[m - 1];
      if (r < 13) begin
         d.abbr = d.abbr ^ (ABBR_W'(1) << $urandom_range(0, ABBR_W - 1));
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
         d.year = YEAR_W'($urandom_range(1970, 9999));
      end else if (r < 82) begin
         d.year = YEAR_W'($urandom_range(0, 1969));
      end else if (r < 92) begin
         d.year = YEAR_W'($urandom_range(10000, 16383));
      end else begin
         d.year = YEAR_W'($urandom_range(1965, 1975));
      end
      len = month_span(int'(d.year), m);
      r = $urandom_range(0, 99);
      if (r < 80) begin
         d.day = FIELD_W'($urandom_range(1, len));
      end else if (r < 92) begin
         d.day = FIELD_W'($urandom_range(len - 1, len + 1));
      end else begin
         d.day = FIELD_W'($urandom_range(0, 127));
      end
      if ($urandom_range(0, 9) != 0) begin
         d.hour   = FIELD_W'($urandom_range(0, 23));
         d.minute = FIELD_W'($urandom_range(0, 59));
         d.second = ($urandom_range(0, 19) == 0) ? FIELD_W'(60) : FIELD_W'($urandom_range(0, 60));
      end else begin
         d.hour   = FIELD_W'($urandom_range(0, 127));
         d.minute = FIELD_W'($urandom_range(0, 127));
         d.second = FIELD_W'($urandom_range(0, 127));
      end
      d.utc = ($urandom_range(0, 19) != 0);
      return d;
   endfunction

   task automatic send_date(input date_type d);
      int unsigned gap;
      gap = send_steady ? 0 : pause_len();
      if (gap != 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.year        = d.year;
      req_ch.month_abbr  = d.abbr;
      req_ch.day         = d.day;
      req_ch.hour        = d.hour;
      req_ch.minute      = d.minute;
      req_ch.second      = d.second;
      req_ch.zone_is_utc = d.utc;
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if ($urandom_range(0, 39) == 0) begin
         send_steady = !send_steady;
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.year        = '0;
      req_ch.month_abbr  = '0;
      req_ch.day         = '0;
      req_ch.hour        = '0;
      req_ch.minute      = '0;
      req_ch.second      = '0;
      req_ch.zone_is_utc = 1'b0;
      rsp_ch.ready       = 1'b0;
   end

   // Result side backpressure, changed at the falling edge.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (stall_left == 0 && !take_steady && $urandom_range(0, 3) == 0) begin
            stall_left = pause_len();
         end
         if (stall_left != 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
         if ($urandom_range(0, 199) == 0) begin
            take_steady = !take_steady;
         end
      end
   end

   // Both channels are scored at the rising edge: inputs first, then results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_date(date_of(req_ch.year, req_ch.month_abbr, req_ch.day, req_ch.hour,
                                 req_ch.minute, req_ch.second, req_ch.zone_is_utc));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_stamp(rsp_ch.epoch_seconds, rsp_ch.status);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, sb.stamps_due.size());
            $display("rfc822_date_to_epoch_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      date_type directed[$];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back(date_of(1970, "Jan", 1, 0, 0, 0, 1));       // the epoch itself
      directed.push_back(date_of(1969, "Dec", 31, 23, 59, 59, 1));   // one second early
      directed.push_back(date_of(1969, "Dec", 31, 23, 59, 60, 1));   // leap second lands on 0
      directed.push_back(date_of(2000, "Feb", 29, 12, 34, 56, 1));
      directed.push_back(date_of(1900, "Feb", 29, 0, 0, 0, 1));     // century, not leap
      directed.push_back(date_of(0, "Feb", 29, 0, 0, 0, 1));        // year 0 is leap, but early
      directed.push_back(date_of(9999, "Dec", 31, 23, 59, 60, 1));
      directed.push_back(date_of(16383, "Dec", 31, 23, 59, 59, 1)); // epoch field wraps
      directed.push_back(date_of(2024, "Mar", 31, 1, 2, 3, 1));
      directed.push_back(date_of(2024, "Apr", 31, 0, 0, 0, 1));
      directed.push_back(date_of(2038, "May", 31, 4, 5, 6, 1));
      directed.push_back(date_of(2038, "Jun", 30, 7, 8, 9, 1));
      directed.push_back(date_of(2038, "Jul", 31, 10, 11, 12, 1));
      directed.push_back(date_of(2038, "Aug", 31, 13, 14, 15, 1));
      directed.push_back(date_of(2038, "Sep", 31, 0, 0, 0, 1));
      directed.push_back(date_of(2038, "Oct", 31, 16, 17, 18, 1));
      directed.push_back(date_of(2038, "Nov", 30, 19, 20, 21, 1));
      directed.push_back(date_of(2038, "Jan", 0, 0, 0, 0, 1));
      directed.push_back(date_of(2038, "Jan", 127, 127, 127, 127, 0)); // day checked first
      directed.push_back(date_of(2038, "Jan", 15, 24, 0, 0, 1));
      directed.push_back(date_of(2038, "Jan", 15, 23, 60, 0, 1));
      directed.push_back(date_of(2038, "Jan", 15, 23, 59, 61, 0));     // time before zone
      directed.push_back(date_of(2038, "Jan", 15, 12, 0, 0, 0));
      directed.push_back(date_of(2038, "jan", 15, 12, 0, 0, 1));       // names are case-sensitive
      directed.push_back(date_of(2038, 24'hFFFFFF, 0, 0, 0, 0, 1));
      directed.push_back(date_of(2038, 24'h000000, 1, 0, 0, 0, 1));

      foreach (directed[i]) begin
         send_date(directed[i]);
      end
      for (int i = 0; i < RANDOM_DATES; i++) begin
         send_date(random_date());
      end
      @(negedge clock);
      req_ch.valid = 1'b0;

      while (sb.stamps_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("rfc822_date_to_epoch_tb: done, clean");
      end else begin
         $display("rfc822_date_to_epoch_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/rde_pkg.sv
hw/rtl/rde_if.sv
hw/rtl/rde_decode.sv
hw/rtl/rde_days.sv
hw/rtl/rde_secs.sv
hw/rtl/rfc822_date_to_epoch.sv
tb/sv/rfc822_date_to_epoch_tb.sv
